/* rtl/sacr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacr_pkg: shared types and constants for the swept box collision resolver.
// Holds the sequencer state type, the field kinds and the saturation limits.
// ----------------------------------------------------------------------------
package sacr_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam logic KIND_BEGIN    = 1'b0;
  localparam logic KIND_NEIGHBOR = 1'b1;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  // Sequencer states of the resolver.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_LOAD,
    ST_DIV_RUN,
    ST_DIV_DONE,
    ST_CHECK,
    ST_MUL_X,
    ST_MUL_Y,
    ST_NORMAL,
    ST_UPDATE,
    ST_EMIT,
    ST_OUT
  } state_t;

  // Saturate a 35 bit signed value to 32 bits.
  function automatic logic signed [31:0] sat35(input logic signed [34:0] v);
    logic signed [31:0] r;
    begin
      if (v > 35'sd2147483647) begin
        r = S32_MAX;
      end else if (v < -35'sd2147483648) begin
        r = S32_MIN;
      end else begin
        r = v[31:0];
      end
      return r;
    end
  endfunction

endpackage

/* rtl/swept_aabb_collision_resolve_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swept_aabb_collision_resolve_unit
// Resolves a swept 2D box move against a stream of neighbour boxes with a
// slab test, using one shared restoring divider and one shared multiplier.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake            Content
// in_      in   in_tvalid/in_tready  begin or neighbour box, tlast ends sweep
// out_     out  out_tvalid/out_tready resolved position and hit description
//
// A begin, a self neighbour or any neighbour under a zero step skips the divider.
// A tested neighbour runs the bit-per-cycle divider once per quotient, four
// times (twice with one step axis zero); a hit adds the multiply, normal and update states.
// On tlast the result is registered in ST_EMIT and held until taken.
// in_tready is low while a transaction is in work or a result is held.
// Reset (rst_n low, synchronous) clears the mover and the kept hit.
// ----------------------------------------------------------------------------
module swept_aabb_collision_resolve_unit #(
  parameter int FRAC_BITS = sacr_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // tdata: center_x[31:0], center_y[63:32], half_w[94:64], half_h[125:95],
  //        step_x[157:126], step_y[189:158], zero fill [191:190]
  input  logic [191:0] in_tdata,
  // tuser: kind[0], is_self[1]
  input  logic [1:0]   in_tuser,
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  // tdata: new_x[31:0], new_y[63:32], hit[64], hit_time[96:65],
  //        normal_x[98:97], normal_y[100:99], zero fill [103:101]
  output logic [103:0] out_tdata
);
  import sacr_pkg::*;

  localparam int DW = FRAC_BITS + 35;   // scaled numerator width
  localparam int CW = $clog2(DW + 1);

  logic signed [31:0] in_cx, in_cy, in_sx, in_sy;
  logic [30:0] in_hw, in_hh;
  assign in_cx = in_tdata[31:0];
  assign in_cy = in_tdata[63:32];
  assign in_hw = in_tdata[94:64];
  assign in_hh = in_tdata[125:95];
  assign in_sx = in_tdata[157:126];
  assign in_sy = in_tdata[189:158];

  state_t state_r, state_nxt;

  logic signed [31:0] mover_x_r, mover_y_r, move_x_r, move_y_r;
  logic [30:0] mhw_r, mhh_r;
  logic best_valid_r;
  logic signed [31:0] best_time_r, best_px_r, best_py_r;
  logic signed [1:0] best_nx_r, best_ny_r;

  // Neighbour working registers
  logic signed [31:0] ncx_r, ncy_r;
  logic [31:0] gw_r, gh_r;
  logic last_r;
  logic [1:0] dsel_r;                 // which of the four quotients
  logic signed [31:0] tq_r [4];
  logic signed [31:0] hx_r, hy_r, entry_r;
  logic signed [1:0] nx_r, ny_r;
  logic ok_r;

  // Divider registers
  logic [DW-1:0] dnum_r;
  logic [33:0] drem_r;
  logic [31:0] dden_r;
  logic dneg_r;
  logic [CW-1:0] dcnt_r;

  logic [103:0] out_data_r;
  logic out_valid_r;

  assign in_tready  = (state_r == ST_IDLE) && !out_valid_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  logic in_acc;
  assign in_acc = in_tvalid && in_tready;

  // Slab bounds as 34 bit signed
  logic signed [33:0] minx, maxx, miny, maxy;
  assign minx = 34'(ncx_r) - $signed({2'b00, gw_r});
  assign maxx = 34'(ncx_r) + $signed({2'b00, gw_r});
  assign miny = 34'(ncy_r) - $signed({2'b00, gh_r});
  assign maxy = 34'(ncy_r) + $signed({2'b00, gh_r});

  // Numerator and denominator for the selected quotient
  logic signed [33:0] num_sel;
  logic signed [31:0] den_sel;
  always_comb begin
    case (dsel_r)
      2'd0:    begin num_sel = minx - 34'(mover_x_r); den_sel = move_x_r; end
      2'd1:    begin num_sel = maxx - 34'(mover_x_r); den_sel = move_x_r; end
      2'd2:    begin num_sel = miny - 34'(mover_y_r); den_sel = move_y_r; end
      default: begin num_sel = maxy - 34'(mover_y_r); den_sel = move_y_r; end
    endcase
  end

  // One restoring step of the shared divider
  logic [34:0] trial;
  logic [33:0] rem_shift;
  assign rem_shift = {drem_r[32:0], dnum_r[DW-1]};
  assign trial = {1'b0, rem_shift} - {3'b000, dden_r};

  // Quotient magnitude after the run, signed saturated
  logic [DW-1:0] qmag;
  logic signed [31:0] qsat;
  assign qmag = dnum_r;
  always_comb begin
    if (!dneg_r) begin
      qsat = (|qmag[DW-1:31]) ? S32_MAX : $signed(qmag[31:0]);
    end else begin
      if (|qmag[DW-1:32] || (qmag[31] && |qmag[30:0])) begin
        qsat = S32_MIN;
      end else begin
        qsat = $signed(32'(-qmag[31:0]));
      end
    end
  end

  // Entry and exit from the four quotients
  logic signed [31:0] lo_x, hi_x, lo_y, hi_y, entry_c, exit_c;
  logic skip_x, skip_y, out_x, out_y, hit_c;
  always_comb begin
    skip_x = (move_x_r == 32'sd0);
    skip_y = (move_y_r == 32'sd0);
    lo_x = (tq_r[0] < tq_r[1]) ? tq_r[0] : tq_r[1];
    hi_x = (tq_r[0] > tq_r[1]) ? tq_r[0] : tq_r[1];
    lo_y = (tq_r[2] < tq_r[3]) ? tq_r[2] : tq_r[3];
    hi_y = (tq_r[2] > tq_r[3]) ? tq_r[2] : tq_r[3];
    if (skip_x) begin
      entry_c = lo_y; exit_c = hi_y;
    end else if (skip_y) begin
      entry_c = lo_x; exit_c = hi_x;
    end else begin
      entry_c = (lo_x > lo_y) ? lo_x : lo_y;
      exit_c  = (hi_x < hi_y) ? hi_x : hi_y;
    end
    out_x = skip_x && (34'(mover_x_r) <= minx || 34'(mover_x_r) >= maxx);
    out_y = skip_y && (34'(mover_y_r) <= miny || 34'(mover_y_r) >= maxy);
    hit_c = !(skip_x && skip_y) && !out_x && !out_y && (exit_c > entry_c) &&
            (exit_c > 32'sd0) && (entry_c < $signed(32'(1) <<< FRAC_BITS));
  end

  // Shared multiplier: step times entry, floor shift
  logic signed [31:0] mul_a;
  logic signed [63:0] prod;
  logic signed [63:0] prod_sh;
  logic signed [31:0] mul_pos;
  assign mul_a   = (state_r == ST_MUL_X) ? move_x_r : move_y_r;
  assign prod    = mul_a * entry_r;
  assign prod_sh = prod >>> FRAC_BITS;
  assign mul_pos = (state_r == ST_MUL_X) ? mover_x_r : mover_y_r;
  // The shifted product can reach far beyond 32 bits, so add at full width.
  logic signed [63:0] mul_wide;
  logic signed [31:0] mul_sum;
  assign mul_wide = 64'(mul_pos) + prod_sh;
  assign mul_sum  = (mul_wide > 64'sd2147483647) ? S32_MAX :
                    (mul_wide < -64'sd2147483648) ? S32_MIN : mul_wide[31:0];

  // Normal from hit point
  logic signed [33:0] dx, dy, adx, ady, penx, peny;
  logic signed [1:0] nx_c, ny_c;
  always_comb begin
    dx = 34'(hx_r) - 34'(ncx_r);
    dy = 34'(hy_r) - 34'(ncy_r);
    adx = dx[33] ? -dx : dx;
    ady = dy[33] ? -dy : dy;
    penx = $signed({2'b00, gw_r}) - adx;
    peny = $signed({2'b00, gh_r}) - ady;
    nx_c = 2'sd0;
    ny_c = 2'sd0;
    if (penx < peny) begin
      nx_c = dx[33] ? -2'sd1 : ((dx != 0) ? 2'sd1 : 2'sd0);
    end else begin
      ny_c = dy[33] ? -2'sd1 : ((dy != 0) ? 2'sd1 : 2'sd0);
    end
  end

  // Tie rule on the dominant step axis
  logic [32:0] amx, amy;
  logic take;
  assign amx = move_x_r[31] ? 33'(-34'(move_x_r)) : 33'(move_x_r);
  assign amy = move_y_r[31] ? 33'(-34'(move_y_r)) : 33'(move_y_r);
  assign take = (entry_r < best_time_r) || ((entry_r == best_time_r) &&
                ((amx > amy && nx_r != 0) || (amy > amx && ny_r != 0)));

  // Resolved position
  logic signed [31:0] rx, ry;
  always_comb begin
    if (best_valid_r) begin
      rx = (best_ny_r != 0) ? sat35(35'(best_px_r) + 35'(move_x_r)) : best_px_r;
      ry = (best_nx_r != 0) ? sat35(35'(best_py_r) + 35'(move_y_r)) : best_py_r;
    end else begin
      rx = sat35(35'(mover_x_r) + 35'(move_x_r));
      ry = sat35(35'(mover_y_r) + 35'(move_y_r));
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser[0] == KIND_NEIGHBOR && !in_tuser[1] &&
              !(move_x_r == 0 && move_y_r == 0)) begin
            state_nxt = ST_DIV_LOAD;
          end else if (in_tlast) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_DIV_LOAD: state_nxt = ST_DIV_RUN;
      ST_DIV_RUN:  state_nxt = (dcnt_r == CW'(1)) ? ST_DIV_DONE : ST_DIV_RUN;
      ST_DIV_DONE: state_nxt = (dsel_r == 2'd3 || (dsel_r == 2'd1 && move_y_r == 0)) ?
                               ST_CHECK : ST_DIV_LOAD;
      ST_CHECK:    state_nxt = hit_c ? ST_MUL_X : (last_r ? ST_EMIT : ST_IDLE);
      ST_MUL_X:    state_nxt = ST_MUL_Y;
      ST_MUL_Y:    state_nxt = ST_NORMAL;
      ST_NORMAL:   state_nxt = ST_UPDATE;
      ST_UPDATE:   state_nxt = last_r ? ST_EMIT : ST_IDLE;
      ST_EMIT:     state_nxt = ST_OUT;
      ST_OUT:      state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Mover, kept hit and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mover_x_r <= '0; mover_y_r <= '0; move_x_r <= '0; move_y_r <= '0;
      mhw_r <= '0; mhh_r <= '0;
      best_valid_r <= 1'b0; best_time_r <= S32_MAX;
      best_px_r <= '0; best_py_r <= '0; best_nx_r <= '0; best_ny_r <= '0;
      out_valid_r <= 1'b0;
      last_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (in_acc) begin
        last_r <= in_tlast;
        if (in_tuser[0] == KIND_BEGIN) begin
          mover_x_r <= in_cx; mover_y_r <= in_cy;
          mhw_r <= in_hw; mhh_r <= in_hh;
          move_x_r <= in_sx; move_y_r <= in_sy;
          best_valid_r <= 1'b0; best_time_r <= S32_MAX;
          best_px_r <= '0; best_py_r <= '0; best_nx_r <= '0; best_ny_r <= '0;
        end
      end
      if (state_r == ST_UPDATE && take) begin
        best_valid_r <= 1'b1; best_time_r <= entry_r;
        best_px_r <= hx_r; best_py_r <= hy_r;
        best_nx_r <= nx_r; best_ny_r <= ny_r;
      end
      if (state_r == ST_EMIT) begin
        out_valid_r <= 1'b1;
        mover_x_r <= rx; mover_y_r <= ry;
        best_valid_r <= 1'b0; best_time_r <= S32_MAX;
        best_px_r <= '0; best_py_r <= '0; best_nx_r <= '0; best_ny_r <= '0;
      end
    end
  end

  // Output payload, captured with the resolved position
  always_ff @(posedge clk) begin
    if (state_r == ST_EMIT) begin
      out_data_r <= {3'b000,
                     best_valid_r ? best_ny_r : 2'sd0,
                     best_valid_r ? best_nx_r : 2'sd0,
                     best_valid_r ? best_time_r : 32'sd0,
                     best_valid_r, ry, rx};
    end
  end

  // Neighbour datapath: divider, multiplier and normal stages
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ncx_r <= in_cx; ncy_r <= in_cy;
      gw_r <= 32'(in_hw) + 32'(mhw_r);
      gh_r <= 32'(in_hh) + 32'(mhh_r);
      dsel_r <= (move_x_r == 0) ? 2'd2 : 2'd0;
    end
    case (state_r)
      ST_DIV_LOAD: begin
        dnum_r <= DW'(num_sel[33] ? -num_sel : num_sel) << FRAC_BITS;
        dden_r <= den_sel[31] ? 32'(-33'(den_sel)) : 32'(den_sel);
        dneg_r <= num_sel[33] ^ den_sel[31];
        drem_r <= '0;
        dcnt_r <= CW'(DW);
      end
      ST_DIV_RUN: begin
        if (!trial[34]) begin
          drem_r <= trial[33:0];
          dnum_r <= {dnum_r[DW-2:0], 1'b1};
        end else begin
          drem_r <= rem_shift;
          dnum_r <= {dnum_r[DW-2:0], 1'b0};
        end
        dcnt_r <= dcnt_r - CW'(1);
      end
      ST_DIV_DONE: begin
        tq_r[dsel_r] <= qsat;
        dsel_r <= (dsel_r == 2'd1 && move_y_r == 0) ? 2'd3 : dsel_r + 2'd1;
      end
      ST_CHECK: entry_r <= entry_c;
      ST_MUL_X: hx_r <= mul_sum;
      ST_MUL_Y: hy_r <= mul_sum;
      ST_NORMAL: begin
        nx_r <= nx_c; ny_r <= ny_c;
      end
      default: ;
    endcase
  end

endmodule

/* rtl/sacr_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacr_checker: port level checks for the collision resolver.
// Watches the stream handshakes and the result fields over time.
// ----------------------------------------------------------------------------
module sacr_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         in_tlast,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [103:0] out_tdata
);

  // A held result keeps its payload until taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // The input is never taken while a result waits.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input ready with pending result");

  // A miss carries zero time and zero normals.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[64] |-> out_tdata[100:65] == 36'd0)
    else $error("miss with nonzero hit fields");

  // A hit has at most one nonzero normal component.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[64] |-> (out_tdata[98:97] == 2'b00 || out_tdata[100:99] == 2'b00))
    else $error("both normal components set");

  // An input without tlast yields no result next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tlast |=> !out_tvalid)
    else $error("result without tlast");

endmodule

bind swept_aabb_collision_resolve_unit sacr_checker u_sacr_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .in_tlast(in_tlast), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata)
);

/* tb/swept_aabb_collision_resolve_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swept_aabb_collision_resolve_unit_tb
// Drives sweeps of begin and neighbour boxes into the collision resolver.
// Each accepted transaction updates a local model of the mover and of the
// earliest hit. Every result is checked field by field against that model.
// ----------------------------------------------------------------------------
module swept_aabb_collision_resolve_unit_tb;
  import sacr_pkg::*;

  localparam int  FX_ONE     = 1 << FRAC_BITS_DEF;
  localparam int  DRAIN_CYC  = 400;
  localparam int  WAIT_LIMIT = 200000;

  typedef struct {
    logic               kind;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic [30:0]        hw;
    logic [30:0]        hh;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic               is_self;
    logic               last;
  } box_item_t;

  typedef struct {
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic               hit;
    logic signed [31:0] hit_time;
    logic signed [1:0]  normal_x;
    logic signed [1:0]  normal_y;
  } resolve_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  // tdata: center_x, center_y, half_w, half_h, step_x, step_y, zero fill
  logic [191:0] in_tdata;
  // tuser: kind, is_self
  logic [1:0]   in_tuser;
  logic         in_tlast;
  logic         out_tvalid;
  logic         out_tready;
  // tdata: new_x, new_y, hit, hit_time, normal_x, normal_y, zero fill
  logic [103:0] out_tdata;

  resolve_t resolve_q[$];
  int       fail_count;
  int       send_idle_pct;
  int       recv_idle_pct;

  // Local copy of the mover and of the kept hit.
  longint mov_x, mov_y, mov_hw, mov_hh, step_x, step_y;
  bit     hit_kept;
  longint hit_t, hit_px, hit_py, hit_nx, hit_ny;

  swept_aabb_collision_resolve_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint sign_of(longint v);
    return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
  endfunction

  // Fixed point quotient, truncated towards zero and saturated.
  function automatic longint slab_div(longint num, longint den);
    longint scaled;
    scaled = num * FX_ONE;
    return clamp32(scaled / den);
  endfunction

  // Fixed point product, rounded towards minus infinity.
  function automatic longint scale_floor(longint a, longint t);
    longint p;
    p = a * t;
    if (p >= 0) return p >>> FRAC_BITS_DEF;
    return -((-p + (FX_ONE - 1)) >>> FRAC_BITS_DEF);
  endfunction

  function automatic void forget_hit();
    hit_kept = 1'b0;
    hit_t    = 64'sd2147483647;
    hit_px   = 0;
    hit_py   = 0;
    hit_nx   = 0;
    hit_ny   = 0;
  endfunction

  // Slab test of the mover against one neighbour grown by the mover size.
  function automatic void slab_test(longint cx, longint cy, longint hw, longint hh);
    longint gw, gh, lo_x, hi_x, lo_y, hi_y, t_in, t_out, ta, tb;
    longint px, py, dx, dy, nx, ny;
    gw = hw + mov_hw;
    gh = hh + mov_hh;
    lo_x = cx - gw; hi_x = cx + gw; lo_y = cy - gh; hi_y = cy + gh;
    t_in = 64'h8000_0000_0000_0000;
    t_out = 64'h7FFF_FFFF_FFFF_FFFF;
    nx = 0;
    ny = 0;
    if (step_x == 0 && step_y == 0) return;
    if (step_x != 0) begin
      ta = slab_div(lo_x - mov_x, step_x);
      tb = slab_div(hi_x - mov_x, step_x);
      if (((ta < tb) ? ta : tb) > t_in) t_in = (ta < tb) ? ta : tb;
      if (((ta > tb) ? ta : tb) < t_out) t_out = (ta > tb) ? ta : tb;
    end else if (mov_x <= lo_x || mov_x >= hi_x) begin
      return;
    end
    if (step_y != 0) begin
      ta = slab_div(lo_y - mov_y, step_y);
      tb = slab_div(hi_y - mov_y, step_y);
      if (((ta < tb) ? ta : tb) > t_in) t_in = (ta < tb) ? ta : tb;
      if (((ta > tb) ? ta : tb) < t_out) t_out = (ta > tb) ? ta : tb;
    end else if (mov_y <= lo_y || mov_y >= hi_y) begin
      return;
    end
    if (!(t_out > t_in && t_out > 0 && t_in < FX_ONE)) return;
    px = clamp32(mov_x + scale_floor(step_x, t_in));
    py = clamp32(mov_y + scale_floor(step_y, t_in));
    dx = px - cx;
    dy = py - cy;
    if ((gw - mag(dx)) < (gh - mag(dy))) nx = sign_of(dx);
    else ny = sign_of(dy);
    if (t_in < hit_t ||
        (t_in == hit_t &&
         ((mag(step_x) > mag(step_y) && nx != 0) ||
          (mag(step_y) > mag(step_x) && ny != 0)))) begin
      hit_kept = 1'b1;
      hit_t = t_in;
      hit_px = px; hit_py = py;
      hit_nx = nx; hit_ny = ny;
    end
  endfunction

  // Advance the model by one accepted transaction; queue a result on tlast.
  function automatic void resolve_item(box_item_t it);
    resolve_t r;
    longint   nxp, nyp;
    if (it.kind == KIND_BEGIN) begin
      mov_x = it.cx; mov_y = it.cy;
      mov_hw = it.hw; mov_hh = it.hh;
      step_x = it.sx; step_y = it.sy;
      forget_hit();
    end else if (!it.is_self) begin
      slab_test(it.cx, it.cy, it.hw, it.hh);
    end
    if (!it.last) return;
    if (hit_kept) begin
      nxp = hit_px;
      nyp = hit_py;
      if (hit_ny != 0) nxp = clamp32(nxp + step_x);
      if (hit_nx != 0) nyp = clamp32(nyp + step_y);
    end else begin
      nxp = clamp32(mov_x + step_x);
      nyp = clamp32(mov_y + step_y);
    end
    r.new_x    = nxp[31:0];
    r.new_y    = nyp[31:0];
    r.hit      = hit_kept;
    r.hit_time = hit_kept ? hit_t[31:0] : 32'sd0;
    r.normal_x = hit_kept ? hit_nx[1:0] : 2'sd0;
    r.normal_y = hit_kept ? hit_ny[1:0] : 2'sd0;
    resolve_q.push_back(r);
    mov_x = nxp;
    mov_y = nyp;
    forget_hit();
  endfunction

  // Offer one transaction, with random idle cycles before it.
  task automatic send_box(box_item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, it.sy, it.sx, it.hh, it.hw, it.cy, it.cx};
    in_tuser  <= {it.is_self, it.kind};
    in_tlast  <= it.last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    resolve_item(it);
  endtask

  function automatic box_item_t make_box(logic kind, int cx, int cy, int hw, int hh,
                                         int sx, int sy, logic is_self, logic last);
    box_item_t it;
    it.kind = kind; it.cx = cx; it.cy = cy; it.hw = hw[30:0]; it.hh = hh[30:0];
    it.sx = sx; it.sy = sy; it.is_self = is_self; it.last = last;
    return it;
  endfunction

  // Random Q16.16 value in [-lim, lim] whole units with a random fraction.
  function automatic int rand_fx(int lim);
    return ($signed($urandom_range(0, 2 * lim)) - lim) * FX_ONE + $urandom_range(0, FX_ONE - 1);
  endfunction

  // Stall the sender until every queued result has been taken.
  task automatic wait_results_drained();
    int n;
    n = 0;
    in_tvalid <= 1'b0;
    while (resolve_q.size() != 0 && n < WAIT_LIMIT) begin
      @(posedge clk);
      n++;
    end
  endtask

  // Receiver: random back-pressure and the result check.
  always @(posedge clk) begin
    resolve_t exp_r, got;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      if (out_tvalid && out_tready) begin
        got.new_x    = out_tdata[31:0];
        got.new_y    = out_tdata[63:32];
        got.hit      = out_tdata[64];
        got.hit_time = out_tdata[96:65];
        got.normal_x = out_tdata[98:97];
        got.normal_y = out_tdata[100:99];
        if (resolve_q.size() == 0) begin
          $error("unexpected result transaction: %h", out_tdata);
          fail_count++;
        end else begin
          exp_r = resolve_q.pop_front();
          if (got.new_x !== exp_r.new_x) begin
            $error("new_x expected %0d actual %0d", exp_r.new_x, got.new_x);
            fail_count++;
          end
          if (got.new_y !== exp_r.new_y) begin
            $error("new_y expected %0d actual %0d", exp_r.new_y, got.new_y);
            fail_count++;
          end
          if (got.hit !== exp_r.hit) begin
            $error("hit expected %0d actual %0d", exp_r.hit, got.hit);
            fail_count++;
          end
          if (got.hit_time !== exp_r.hit_time) begin
            $error("hit_time expected %0d actual %0d", exp_r.hit_time, got.hit_time);
            fail_count++;
          end
          if (got.normal_x !== exp_r.normal_x) begin
            $error("normal_x expected %0d actual %0d", exp_r.normal_x, got.normal_x);
            fail_count++;
          end
          if (got.normal_y !== exp_r.normal_y) begin
            $error("normal_y expected %0d actual %0d", exp_r.normal_y, got.normal_y);
            fail_count++;
          end
        end
      end
    end
  end

  // Directed cases: edges of the fields and the special situations.
  task automatic test_directed();
    int one;
    one = FX_ONE;
    // Neighbour before any begin, against the all-zero mover.
    send_box(make_box(KIND_NEIGHBOR, one, 0, one, one, 0, 0, 1'b0, 1'b1));
    // Begin with tlast and a zero step: no hit, no move.
    send_box(make_box(KIND_BEGIN, 3 * one, -2 * one, one, one, 0, 0, 1'b0, 1'b1));
    // Plain head-on hit, then a skipped self neighbour that closes the sweep.
    send_box(make_box(KIND_BEGIN, 0, 0, one, one, 10 * one, 0, 1'b0, 1'b0));
    send_box(make_box(KIND_NEIGHBOR, 6 * one, 0, one, one, 0, 0, 1'b0, 1'b0));
    send_box(make_box(KIND_NEIGHBOR, 3 * one, 0, one, one, 0, 0, 1'b1, 1'b1));
    // Two neighbours with the same entry time on the dominant axis.
    send_box(make_box(KIND_BEGIN, 0, 0, one, one, 10 * one, 2 * one, 1'b0, 1'b0));
    send_box(make_box(KIND_NEIGHBOR, 6 * one, 0, one, 2 * one, 0, 0, 1'b0, 1'b0));
    send_box(make_box(KIND_NEIGHBOR, 6 * one, one, one, 2 * one, 0, 0, 1'b0, 1'b1));
    // Sweep continued without a new begin.
    send_box(make_box(KIND_NEIGHBOR, 20 * one, 2 * one, one, one, 0, 0, 1'b0, 1'b1));
    // Diagonal glancing hit on the y side.
    send_box(make_box(KIND_BEGIN, 0, 0, one / 2, one / 2, 4 * one, 8 * one, 1'b0, 1'b0));
    send_box(make_box(KIND_NEIGHBOR, 2 * one, 6 * one, 3 * one, one, 0, 0, 1'b0, 1'b1));
    // Zero step on y with the centre outside the grown slab.
    send_box(make_box(KIND_BEGIN, 0, 2 * one, one, one, 10 * one, 0, 1'b0, 1'b0));
    send_box(make_box(KIND_NEIGHBOR, 5 * one, 0, one, 0, 0, 0, 1'b0, 1'b1));
    // Saturating sums at both ends of the range.
    send_box(make_box(KIND_BEGIN, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b1));
    send_box(make_box(KIND_BEGIN, 32'h8000_0000, 32'h8000_0000, 0, 0,
                      32'h8000_0000, 32'h8000_0000, 1'b1, 1'b1));
    // Mover already inside a huge box, with saturating quotients.
    send_box(make_box(KIND_BEGIN, 0, 0, 0, 0, 1, -1, 1'b0, 1'b0));
    send_box(make_box(KIND_NEIGHBOR, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 1'b0, 1'b0));
    send_box(make_box(KIND_NEIGHBOR, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0,
                      32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b1));
    // Extreme step with far neighbour, and a neighbour carrying step bits.
    send_box(make_box(KIND_BEGIN, 32'h8000_0000, 0, 0, one, 32'h7FFF_FFFF, 0, 1'b0, 1'b0));
    send_box(make_box(KIND_NEIGHBOR, 32'h7FFF_0000, 0, one, one, -1, -1, 1'b0, 1'b1));
  endtask

  // Random sweeps, mostly well formed with neighbours near the path.
  task automatic test_random_sweeps(int n_items);
    box_item_t it;
    int        sent, n_nb, mx, my, sx, sy, k;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        // Noise: every field fully random.
        it.kind = 1'($urandom); it.cx = $urandom; it.cy = $urandom;
        it.hw = 31'($urandom); it.hh = 31'($urandom); it.sx = $urandom; it.sy = $urandom;
        it.is_self = 1'($urandom); it.last = ($urandom_range(0, 2) == 0);
        send_box(it);
        sent++;
      end else begin
        mx = rand_fx(200);
        my = rand_fx(200);
        sx = ($urandom_range(0, 7) == 0) ? 0 : rand_fx(60);
        sy = ($urandom_range(0, 7) == 0) ? 0 : rand_fx(60);
        n_nb = $urandom_range(0, 4);
        if ($urandom_range(0, 9) != 0) begin
          send_box(make_box(KIND_BEGIN, mx, my, $urandom_range(0, 8 * FX_ONE),
                            $urandom_range(0, 8 * FX_ONE), sx, sy, 1'($urandom),
                            n_nb == 0));
          sent++;
        end else begin
          // Continue from the current mover.
          mx = int'(mov_x); my = int'(mov_y); sx = int'(step_x); sy = int'(step_y);
          if (n_nb == 0) n_nb = 1;
        end
        for (k = 0; k < n_nb; k++) begin
          it = make_box(KIND_NEIGHBOR,
                        mx + (sx / 4) * $urandom_range(0, 5) + rand_fx(6),
                        my + (sy / 4) * $urandom_range(0, 5) + rand_fx(6),
                        $urandom_range(0, 20 * FX_ONE), $urandom_range(0, 20 * FX_ONE),
                        $urandom, $urandom, ($urandom_range(0, 9) == 0), k == n_nb - 1);
          send_box(it);
          sent++;
        end
      end
    end
  endtask

  initial begin
    int n;
    fail_count = 0;
    send_idle_pct = 36;
    recv_idle_pct = 47;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    in_tlast = 1'b0;
    mov_x = 0; mov_y = 0; mov_hw = 0; mov_hh = 0; step_x = 0; step_y = 0;
    forget_hit();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    wait_results_drained();
    test_random_sweeps(230);
    send_idle_pct = 47;
    recv_idle_pct = 36;
    test_random_sweeps(230);
    wait_results_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_sweeps(230);
    in_tvalid <= 1'b0;

    // Let the last results arrive, then allow some settling time.
    n = 0;
    while (resolve_q.size() != 0 && n < WAIT_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (DRAIN_CYC) @(posedge clk);
    if (fail_count == 0 && resolve_q.size() == 0) begin
      $display("swept_aabb_collision_resolve_unit_tb passed");
    end else begin
      if (resolve_q.size() != 0) $error("%0d results never arrived", resolve_q.size());
      $display("swept_aabb_collision_resolve_unit_tb failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #30ms;
    $display("swept_aabb_collision_resolve_unit_tb failed");
    $finish;
  end

endmodule
